// ----- rtl/stlbs_pkg.sv -----
// Shared types and constants for the sorted table lower-bound search unit.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package stlbs_pkg;

	localparam int CFG_W   = 11;  // table_size register width
	localparam int STEPS_W = 4;   // iteration count width (wraps)

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // write one table entry
		logic start;  // capture a search item
		logic step;   // one halving iteration
		logic emit;   // load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;   // search interval empty or key rejected
	} sts_t;

endpackage

// ----- rtl/stlbs_if.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on nothing; widths come from the interface parameters.
`timescale 1ns / 1ps

interface stlbs_req_if #(
	parameter int IDX_W = 10,
	parameter int KEY_W = 32
);
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic        [IDX_W-1:0] entry_index;
	logic signed [KEY_W-1:0] entry_key;
	logic signed [KEY_W-1:0] search_key;

	modport source (
		output valid, req_type, entry_index, entry_key, search_key,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, entry_key, search_key,
		output ready
	);
endinterface

interface stlbs_rsp_if #(
	parameter int POS_W   = 11,
	parameter int KEY_W   = 32,
	parameter int STEPS_W = 4
);
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic        [POS_W-1:0]   position;
	logic signed [KEY_W-1:0]   found_key;
	logic                      hit;
	logic                      past_end;
	logic        [STEPS_W-1:0] steps;

	modport source (
		output valid, status, position, found_key, hit, past_end, steps,
		input  ready
	);
	modport sink (
		input  valid, status, position, found_key, hit, past_end, steps,
		output ready
	);
endinterface

// ----- rtl/stlbs_ctrl.sv -----
// Controller for the lower-bound search: state machine and result valid flag.
// Depends on stlbs_pkg (state_t, cmd_t, sts_t, request codes).
`timescale 1ns / 1ps

module stlbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_req_type,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  stlbs_pkg::sts_t sts,
	output stlbs_pkg::cmd_t cmd
);

	stlbs_pkg::state_t state_q, state_nx;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stlbs_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			stlbs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_req_type == stlbs_pkg::REQ_SEARCH) begin
						cmd.start = 1'b1;
						state_nx  = stlbs_pkg::S_SEARCH;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			stlbs_pkg::S_SEARCH: begin
				if (!sts.done) begin
					cmd.step = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					// result slot free or draining this cycle
					cmd.emit = 1'b1;
					state_nx = stlbs_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = stlbs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/stlbs_dp.sv -----
// Datapath for the lower-bound search: key table memory, size register,
// search interval registers and result register. Depends on stlbs_pkg.
`timescale 1ns / 1ps

module stlbs_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stlbs_pkg::CFG_W-1:0]         cfg_wdata,
	input  stlbs_pkg::cmd_t                     cmd,
	output stlbs_pkg::sts_t                     sts,
	input  logic [$clog2(TABLE_DEPTH)-1:0]      entry_index,
	input  logic signed [KEY_WIDTH-1:0]         entry_key,
	input  logic signed [KEY_WIDTH-1:0]         search_key,
	output logic                                status,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]    position,
	output logic signed [KEY_WIDTH-1:0]         found_key,
	output logic                                hit,
	output logic                                past_end,
	output logic [stlbs_pkg::STEPS_W-1:0]       steps
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int POS_W = $clog2(TABLE_DEPTH + 1);
	localparam int SW    = (stlbs_pkg::CFG_W > POS_W) ? stlbs_pkg::CFG_W : POS_W;
	localparam int CW    = (KEY_WIDTH > stlbs_pkg::CFG_W + 1) ?
	                       KEY_WIDTH : stlbs_pkg::CFG_W + 1;

	logic [stlbs_pkg::CFG_W-1:0] table_size_q;

	logic signed [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic signed [KEY_WIDTH-1:0] rd_q;

	logic signed [KEY_WIDTH-1:0]      key_q;
	logic [POS_W-1:0]                 low_q, high_q, size_q;
	logic [stlbs_pkg::STEPS_W-1:0]    steps_q;
	logic                             invalid_q;

	logic [SW-1:0]          size_ext, size_sat;
	logic [POS_W-1:0]       size_eff;
	logic signed [CW-1:0]   key_cmp, cfg_cmp;
	logic                   key_gt_size;
	logic [POS_W:0]         sum, sum_nx;
	logic [POS_W-1:0]       mid, mid_nx, low_nx, high_nx, addr_full;
	logic                   go_right;
	logic [IDX_W-1:0]       rd_addr;
	logic                   load_ok;
	logic                   past;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	// search range is the size register clamped to the table depth
	always_comb begin
		size_ext = SW'(table_size_q);
		size_sat = (size_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : size_ext;
		size_eff = POS_W'(size_sat);
	end

	// key rejected when it exceeds the raw size register (signed compare)
	always_comb begin
		key_cmp     = CW'(search_key);
		cfg_cmp     = $signed(CW'({1'b0, table_size_q}));
		key_gt_size = key_cmp > cfg_cmp;
	end

	always_comb begin
		sum      = {1'b0, low_q} + {1'b0, high_q};
		mid      = POS_W'(sum >> 1);
		go_right = key_q > rd_q;
		low_nx   = go_right ? POS_W'(mid + POS_W'(1)) : low_q;
		high_nx  = go_right ? high_q : mid;
		sum_nx   = {1'b0, low_nx} + {1'b0, high_nx};
		mid_nx   = POS_W'(sum_nx >> 1);
	end

	// rd_q always holds the entry at the midpoint of the current interval;
	// once the interval closes that is the entry at the final position.
	always_comb begin
		if (cmd.start) begin
			addr_full = size_eff >> 1;
		end else if (cmd.step) begin
			addr_full = mid_nx;
		end else begin
			addr_full = mid;
		end
		rd_addr = (addr_full < POS_W'(TABLE_DEPTH)) ? IDX_W'(addr_full) : '0;
		load_ok = POS_W'(entry_index) < POS_W'(TABLE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			mem[entry_index] <= entry_key;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_q <= 1'b0;
		end else if (cmd.start) begin
			invalid_q <= key_gt_size;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= search_key;
			low_q   <= '0;
			high_q  <= size_eff;
			size_q  <= size_eff;
			steps_q <= '0;
		end else if (cmd.step) begin
			low_q   <= low_nx;
			high_q  <= high_nx;
			steps_q <= steps_q + stlbs_pkg::STEPS_W'(1);
		end
	end

	assign sts.done = invalid_q || !(low_q < high_q);
	assign past     = !invalid_q && (low_q == size_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status    <= invalid_q ? stlbs_pkg::STATUS_INVALID : stlbs_pkg::STATUS_OK;
			position  <= invalid_q ? '0 : low_q;
			found_key <= (invalid_q || past) ? '0 : rd_q;
			hit       <= !invalid_q && !past && (rd_q == key_q);
			past_end  <= past;
			steps     <= invalid_q ? '0 : steps_q;
		end
	end

endmodule

// ----- rtl/sorted_table_lower_bound_search_unit.sv -----
// Lower-bound binary search over a loaded table of ascending signed keys.
// Load item: written in its accept cycle, next item can follow at once.
// Search item: k halving iterations, one per cycle through the registered
// table read, k <= log2(TABLE_DEPTH)+1; result registered once its slot is free.
// One search in flight; the next item follows the result load, also while it waits.
// Reset clears control state and table_size; table contents undefined until loaded.
`timescale 1ns / 1ps

module sorted_table_lower_bound_search_unit #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [stlbs_pkg::CFG_W-1:0] cfg_wdata,
	stlbs_req_if.sink                   req,
	stlbs_rsp_if.source                 rsp
);

	stlbs_pkg::cmd_t cmd;
	stlbs_pkg::sts_t sts;

	stlbs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	stlbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.sts         (sts),
		.entry_index (req.entry_index),
		.entry_key   (req.entry_key),
		.search_key  (req.search_key),
		.status      (rsp.status),
		.position    (rsp.position),
		.found_key   (rsp.found_key),
		.hit         (rsp.hit),
		.past_end    (rsp.past_end),
		.steps       (rsp.steps)
	);

	// a new result only appears at the end of a search, never from idle
	a_rise_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> !$past(req.ready))
		else $error("result raised without a search in flight");

	a_hit_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |->
			!rsp.past_end && rsp.status == stlbs_pkg::STATUS_OK &&
			rsp.position < rsp.position + 1'b1)
		else $error("hit reported past end or on rejected key");

	a_past_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.past_end |-> rsp.found_key == '0)
		else $error("nonzero key reported past end");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == stlbs_pkg::STATUS_INVALID |->
			rsp.position == '0 && rsp.steps == '0 && !rsp.hit && !rsp.past_end)
		else $error("rejected key with nonzero result fields");

endmodule
